/* sv/prls_pkg.sv */
// shared constants, codes and entry layout of the ready-list scheduler
package prls_pkg;

   localparam int MAX_THREADS      = 16;
   localparam int TICKS_PER_SECOND = 100;
   localparam int MS_PER_TICK      = 1000 / TICKS_PER_SECOND;

   localparam int SLOT_W  = $clog2(MAX_THREADS);
   localparam int LEN_W   = $clog2(MAX_THREADS + 1);
   localparam int TICK_W  = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W  = TICK_W + 7;
   localparam int DVD_W   = (PROD_W > 16) ? PROD_W : 16;

   // reciprocal scaling for ms to ticks (16-bit dividend)
   localparam int    MS_SH    = 16 + $clog2(MS_PER_TICK);
   localparam longint MS_RECIP = ((longint'(1) << MS_SH) + MS_PER_TICK - 1) / MS_PER_TICK;
   localparam int    MS_PW    = 16 + MS_SH;

   // reciprocal scaling for idle*100 over the window length
   localparam int    LD_SH    = PROD_W + $clog2(TICKS_PER_SECOND);
   localparam longint LD_RECIP = ((longint'(1) << LD_SH) + TICKS_PER_SECOND - 1) /
                                 TICKS_PER_SECOND;
   localparam int    LD_PW    = PROD_W + LD_SH;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_SLEEP  = 2'd2;
   localparam logic [1:0] OP_SETF   = 2'd3;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_FULL         = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND    = 2'd2;
   localparam logic [1:0] ST_NONE_RUNNABLE = 2'd3;

   localparam logic [1:0] FLAG_SLEEP = 2'b01;
   localparam logic [1:0] FLAG_TERM  = 2'b10;

   typedef struct packed {
      logic [7:0]        tid;
      logic [1:0]        prio;
      logic [1:0]        flags;
      logic [15:0]       count;
      logic [SLOT_W-1:0] link;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* sv/prls_ram.sv */
// generic single-port-write, registered-read ram
module prls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/priority_ready_list_scheduler.sv */
// top level of the priority ready-list thread scheduler
//
// one transaction at a time: start is taken while busy is low, and exactly one
// result follows as a single-cycle rsp_valid strobe, which the receiver must
// take as it comes. all thread entries live in one ram with a registered read,
// so every list step takes an address state and then a data state. an insert
// or a set-flags request walks the list; a dispatch tick walks the list for
// each head move and then runs the sleep countdown over the whole list; a
// sleep transaction first scales ms to ticks with a reciprocal multiply and
// marks the head, and a tick that closes a measurement window adds a step for
// the load figure.
// no clearing pass is needed after reset.
module priority_ready_list_scheduler (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [1:0] req_priority_req,
   input  logic [7:0] req_target_tid,
   input  logic [1:0] req_state_flags,
   input  logic [15:0] req_sleep_ms,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_running_tid,
   output logic [7:0] rsp_new_tid,
   output logic       rsp_load_valid,
   output logic [6:0] rsp_load_percent,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_idle_thread_id
);

   import prls_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_INS_RD, S_INS_EV, S_INS_CHK, S_INS_LINK,
      S_SF_RD, S_SF_EV,
      S_DIV_MS, S_SL_RD, S_SL_EV,
      S_DP_LOOP, S_RQH_RD, S_RQH_EV, S_RQT_RD, S_RQT_EV, S_RQ_WH,
      S_CHK_RD, S_CHK_EV, S_CD_RD, S_CD_EV, S_ACCT, S_DIV_LD
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [MAX_THREADS-1:0] in_use_ff, in_use_in;
   logic [TICK_W-1:0]  idle_ff, idle_in;
   logic [TICK_W-1:0]  win_ff, win_in;
   logic [7:0]         idle_id_ff, idle_id_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-transaction working registers
   logic [1:0]         prio_ff, prio_in;
   logic [7:0]         target_ff, target_in;
   logic [1:0]         flags_ff, flags_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_W-1:0]   budget_ff, budget_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   logic [8:0]         id_ff, id_in;
   logic [7:0]         hdtid_ff, hdtid_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  h_ff, h_in;
   entry_type          hdata_ff, hdata_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   entry_type          tdata_ff, tdata_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;

   // result registers
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_running_tid_ff, rsp_running_tid_in;
   logic [7:0] rsp_new_tid_ff, rsp_new_tid_in;
   logic       rsp_load_valid_ff, rsp_load_valid_in;
   logic [6:0] rsp_load_percent_ff, rsp_load_percent_in;

   // entry ram
   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   entry_type          ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata_raw;
   entry_type          ram_rdata;

   prls_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_THREADS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cur_ff),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = entry_type'(ram_rdata_raw);

   // lowest free slot
   logic [SLOT_W-1:0] free_slot;
   logic              have_free;

   always_comb begin
      free_slot = '0;
      have_free = 1'b0;
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_slot = SLOT_W'(i);
            have_free = 1'b1;
         end
      end
   end

   // constant divisions as reciprocal multiplies, exact over the operand range
   logic [MS_PW-1:0] ms_prod;
   logic [LD_PW-1:0] ld_prod;
   logic [15:0]      ms_q;
   logic [6:0]       ld_q;

   always_comb begin
      ms_prod = MS_PW'(dvd_ff[15:0]) * MS_PW'(MS_RECIP);
      ld_prod = LD_PW'(dvd_ff[PROD_W-1:0]) * LD_PW'(LD_RECIP);
      ms_q    = ms_prod[MS_SH +: 16];
      ld_q    = ld_prod[LD_SH +: 7];
   end

   // main sequencer
   logic [LEN_W-1:0]  cnt_inc;
   logic [LEN_W-1:0]  rest;
   logic              more;
   logic [7:0]        head_tid_now;
   logic [TICK_W-1:0] idle_n;
   logic [TICK_W-1:0] win_n;
   logic [PROD_W-1:0] prod;
   entry_type         e_mod;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      len_in     = len_ff;
      in_use_in  = in_use_ff;
      idle_in    = idle_ff;
      win_in     = win_ff;
      idle_id_in = idle_id_ff;
      prio_in    = prio_ff;
      target_in  = target_ff;
      flags_in   = flags_ff;
      cur_in     = cur_ff;
      cnt_in     = cnt_ff;
      budget_in  = budget_ff;
      k_in       = k_ff;
      id_in      = id_ff;
      hdtid_in   = hdtid_ff;
      found_in   = found_ff;
      h_in       = h_ff;
      hdata_in   = hdata_ff;
      tail_in    = tail_ff;
      tdata_in   = tdata_ff;
      slot_in    = slot_ff;
      dvd_in     = dvd_ff;
      rsp_valid_in        = 1'b0;
      rsp_status_in       = rsp_status_ff;
      rsp_running_tid_in  = rsp_running_tid_ff;
      rsp_new_tid_in      = rsp_new_tid_ff;
      rsp_load_valid_in   = rsp_load_valid_ff;
      rsp_load_percent_in = rsp_load_percent_ff;
      ram_we    = 1'b0;
      ram_waddr = cur_ff;
      ram_wdata = ram_rdata;
      e_mod     = ram_rdata;

      cnt_inc      = LEN_W'(cnt_ff + LEN_W'(1));
      rest         = LEN_W'(len_ff - LEN_W'(1));
      more         = LEN_W'(k_ff + LEN_W'(1)) < rest;
      head_tid_now = (cnt_ff == '0) ? ram_rdata.tid : hdtid_ff;
      idle_n       = TICK_W'(idle_ff + TICK_W'(
                        (!found_ff || hdtid_ff == idle_id_ff) ? 1 : 0));
      win_n        = TICK_W'(win_ff + TICK_W'(1));
      prod         = PROD_W'(idle_n) * PROD_W'(100);

      if (csr_valid) begin
         idle_id_in = csr_idle_thread_id;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               prio_in   = req_priority_req;
               target_in = req_target_tid;
               flags_in  = req_state_flags;
               found_in  = 1'b0;
               cur_in    = head_ff;
               cnt_in    = '0;
               id_in     = 9'd1;
               hdtid_in  = '0;
               budget_in = len_ff;
               unique case (req_opcode)
                  OP_INSERT: begin
                     state_in = (len_ff == '0) ? S_INS_CHK : S_INS_RD;
                  end
                  OP_TICK: begin
                     state_in = S_DP_LOOP;
                  end
                  OP_SLEEP: begin
                     if (len_ff != '0) begin
                        dvd_in   = DVD_W'(req_sleep_ms);
                        state_in = S_DIV_MS;
                     end else begin
                        state_in = S_DP_LOOP;
                     end
                  end
                  OP_SETF: begin
                     if (len_ff == '0) begin
                        rsp_valid_in        = 1'b1;
                        rsp_status_in       = ST_NOT_FOUND;
                        rsp_running_tid_in  = '0;
                        rsp_new_tid_in      = '0;
                        rsp_load_valid_in   = 1'b0;
                        rsp_load_percent_in = '0;
                     end else begin
                        state_in = S_SF_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // insert: walk for largest id and the tail
         S_INS_RD: begin
            state_in = S_INS_EV;
         end
         S_INS_EV: begin
            if (cnt_ff == '0) begin
               hdtid_in = ram_rdata.tid;
            end
            if ({1'b0, ram_rdata.tid} >= id_ff) begin
               id_in = 9'({1'b0, ram_rdata.tid} + 9'd1);
            end
            tail_in  = cur_ff;
            tdata_in = ram_rdata;
            cur_in   = ram_rdata.link;
            cnt_in   = cnt_inc;
            state_in = (cnt_inc == len_ff) ? S_INS_CHK : S_INS_RD;
         end
         S_INS_CHK: begin
            if (len_ff == LEN_W'(MAX_THREADS) || id_ff[8] || !have_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = ST_FULL;
               rsp_running_tid_in  = (len_ff != '0) ? hdtid_ff : 8'd0;
               rsp_new_tid_in      = '0;
               rsp_load_valid_in   = 1'b0;
               rsp_load_percent_in = '0;
               state_in            = S_IDLE;
            end else begin
               ram_we          = 1'b1;
               ram_waddr       = free_slot;
               ram_wdata.tid   = id_ff[7:0];
               ram_wdata.prio  = prio_ff;
               ram_wdata.flags = '0;
               ram_wdata.count = '0;
               ram_wdata.link  = '0;
               in_use_in[free_slot] = 1'b1;
               len_in  = LEN_W'(len_ff + LEN_W'(1));
               slot_in = free_slot;
               if (len_ff == '0) begin
                  head_in             = free_slot;
                  rsp_valid_in        = 1'b1;
                  rsp_status_in       = ST_OK;
                  rsp_running_tid_in  = id_ff[7:0];
                  rsp_new_tid_in      = id_ff[7:0];
                  rsp_load_valid_in   = 1'b0;
                  rsp_load_percent_in = '0;
                  state_in            = S_IDLE;
               end else begin
                  state_in = S_INS_LINK;
               end
            end
         end
         S_INS_LINK: begin
            ram_we         = 1'b1;
            ram_waddr      = tail_ff;
            ram_wdata      = tdata_ff;
            ram_wdata.link = slot_ff;
            rsp_valid_in        = 1'b1;
            rsp_status_in       = ST_OK;
            rsp_running_tid_in  = hdtid_ff;
            rsp_new_tid_in      = id_ff[7:0];
            rsp_load_valid_in   = 1'b0;
            rsp_load_percent_in = '0;
            state_in            = S_IDLE;
         end

         // set flags by id
         S_SF_RD: begin
            state_in = S_SF_EV;
         end
         S_SF_EV: begin
            hdtid_in = head_tid_now;
            if (ram_rdata.tid == target_ff) begin
               ram_we          = 1'b1;
               ram_wdata.flags = ram_rdata.flags | flags_ff;
               rsp_valid_in        = 1'b1;
               rsp_status_in       = ST_OK;
               rsp_running_tid_in  = head_tid_now;
               rsp_new_tid_in      = '0;
               rsp_load_valid_in   = 1'b0;
               rsp_load_percent_in = '0;
               state_in            = S_IDLE;
            end else if (cnt_inc == len_ff) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = ST_NOT_FOUND;
               rsp_running_tid_in  = head_tid_now;
               rsp_new_tid_in      = '0;
               rsp_load_valid_in   = 1'b0;
               rsp_load_percent_in = '0;
               state_in            = S_IDLE;
            end else begin
               cur_in   = ram_rdata.link;
               cnt_in   = cnt_inc;
               state_in = S_SF_RD;
            end
         end

         // sleep: ms to ticks, then mark the head
         S_DIV_MS: begin
            dvd_in   = DVD_W'(ms_q);
            state_in = S_SL_RD;
         end
         S_SL_RD: begin
            state_in = S_SL_EV;
         end
         S_SL_EV: begin
            ram_we          = 1'b1;
            ram_wdata.flags = ram_rdata.flags | FLAG_SLEEP;
            ram_wdata.count = dvd_ff[15:0];
            budget_in       = len_ff;
            state_in        = S_DP_LOOP;
         end

         // dispatch search, at most one pass over the list
         S_DP_LOOP: begin
            cur_in = head_ff;
            if (budget_ff == '0 || len_ff == '0) begin
               cnt_in   = '0;
               state_in = (len_ff == '0) ? S_ACCT : S_CD_RD;
            end else begin
               budget_in = LEN_W'(budget_ff - LEN_W'(1));
               state_in  = (len_ff < LEN_W'(2)) ? S_CHK_RD : S_RQH_RD;
            end
         end
         S_RQH_RD: begin
            state_in = S_RQH_EV;
         end
         S_RQH_EV: begin
            hdata_in = ram_rdata;
            h_in     = cur_ff;
            head_in  = ram_rdata.link;
            cur_in   = ram_rdata.link;
            k_in     = '0;
            state_in = S_RQT_RD;
         end
         S_RQT_RD: begin
            state_in = S_RQT_EV;
         end
         S_RQT_EV: begin
            if (more && ram_rdata.prio <= hdata_ff.prio) begin
               cur_in   = ram_rdata.link;
               k_in     = LEN_W'(k_ff + LEN_W'(1));
               state_in = S_RQT_RD;
            end else begin
               // splice the old head in behind this entry
               ram_we         = 1'b1;
               ram_wdata.link = h_ff;
               hdata_in.link  = more ? ram_rdata.link : '0;
               state_in       = S_RQ_WH;
            end
         end
         S_RQ_WH: begin
            ram_we    = 1'b1;
            ram_waddr = h_ff;
            ram_wdata = hdata_ff;
            cur_in    = head_ff;
            state_in  = S_CHK_RD;
         end
         S_CHK_RD: begin
            state_in = S_CHK_EV;
         end
         S_CHK_EV: begin
            if ((ram_rdata.flags & FLAG_TERM) != '0) begin
               // terminated thread at the head is dropped
               in_use_in[cur_ff] = 1'b0;
               len_in   = rest;
               head_in  = (len_ff > LEN_W'(1)) ? ram_rdata.link : '0;
               state_in = S_DP_LOOP;
            end else if ((ram_rdata.flags & FLAG_SLEEP) == '0) begin
               found_in = 1'b1;
               hdtid_in = ram_rdata.tid;
               cnt_in   = '0;
               state_in = S_CD_RD;
            end else begin
               state_in = S_DP_LOOP;
            end
         end

         // sleep countdown over the whole list
         S_CD_RD: begin
            state_in = S_CD_EV;
         end
         S_CD_EV: begin
            if (ram_rdata.count != '0) begin
               e_mod.count = 16'(ram_rdata.count - 16'd1);
               if (e_mod.count == '0) begin
                  e_mod.flags = ram_rdata.flags & ~FLAG_SLEEP;
               end
               ram_we    = 1'b1;
               ram_wdata = e_mod;
            end
            cur_in   = ram_rdata.link;
            cnt_in   = cnt_inc;
            state_in = (cnt_inc == len_ff) ? S_ACCT : S_CD_RD;
         end

         // idle accounting and load window
         S_ACCT: begin
            rsp_status_in      = found_ff ? ST_OK : ST_NONE_RUNNABLE;
            rsp_running_tid_in = found_ff ? hdtid_ff : 8'd0;
            rsp_new_tid_in     = '0;
            if (win_n >= TICK_W'(TICKS_PER_SECOND)) begin
               idle_in  = '0;
               win_in   = '0;
               dvd_in   = DVD_W'(prod);
               state_in = S_DIV_LD;
            end else begin
               idle_in             = idle_n;
               win_in              = win_n;
               rsp_valid_in        = 1'b1;
               rsp_load_valid_in   = 1'b0;
               rsp_load_percent_in = '0;
               state_in            = S_IDLE;
            end
         end
         S_DIV_LD: begin
            rsp_valid_in        = 1'b1;
            rsp_load_valid_in   = 1'b1;
            rsp_load_percent_in = 7'(7'd100 - ld_q);
            state_in            = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         len_ff       <= '0;
         in_use_ff    <= '0;
         idle_ff      <= '0;
         win_ff       <= '0;
         idle_id_ff   <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         len_ff       <= len_in;
         in_use_ff    <= in_use_in;
         idle_ff      <= idle_in;
         win_ff       <= win_in;
         idle_id_ff   <= idle_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prio_ff   <= prio_in;
      target_ff <= target_in;
      flags_ff  <= flags_in;
      cur_ff    <= cur_in;
      cnt_ff    <= cnt_in;
      budget_ff <= budget_in;
      k_ff      <= k_in;
      id_ff     <= id_in;
      hdtid_ff  <= hdtid_in;
      found_ff  <= found_in;
      h_ff      <= h_in;
      hdata_ff  <= hdata_in;
      tail_ff   <= tail_in;
      tdata_ff  <= tdata_in;
      slot_ff   <= slot_in;
      dvd_ff    <= dvd_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_running_tid_ff  <= rsp_running_tid_in;
      rsp_new_tid_ff      <= rsp_new_tid_in;
      rsp_load_valid_ff   <= rsp_load_valid_in;
      rsp_load_percent_ff <= rsp_load_percent_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_running_tid  = rsp_running_tid_ff;
   assign rsp_new_tid      = rsp_new_tid_ff;
   assign rsp_load_valid   = rsp_load_valid_ff;
   assign rsp_load_percent = rsp_load_percent_ff;

endmodule

/* dv/priority_ready_list_scheduler_tb.sv */
// self-checking testbench of the priority ready-list thread scheduler
module priority_ready_list_scheduler_tb;
   import prls_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int ITEMS_PER_PHASE = 125;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] running_tid;
      logic [7:0] new_tid;
      logic       load_valid;
      logic [6:0] load_percent;
   } sched_result_t;

   // one directed row: the typed result is used only where known is set
   typedef struct {
      logic [1:0]  opcode;
      logic [1:0]  prio;
      logic [7:0]  target;
      logic [1:0]  flags;
      logic [15:0] ms;
      bit          known;
      logic [1:0]  status;
      logic [7:0]  running_tid;
      logic [7:0]  new_tid;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_TICK;
   logic [1:0]  req_priority_req = '0;
   logic [7:0]  req_target_tid = '0;
   logic [1:0]  req_state_flags = '0;
   logic [15:0] req_sleep_ms = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_running_tid;
   logic [7:0]  rsp_new_tid;
   logic        rsp_load_valid;
   logic [6:0]  rsp_load_percent;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_idle_thread_id = '0;

   // scheduler shadow state
   logic [7:0]  sh_tid   [MAX_THREADS];
   logic [1:0]  sh_prio  [MAX_THREADS];
   logic [1:0]  sh_flags [MAX_THREADS];
   logic [15:0] sh_count [MAX_THREADS];
   int          sh_link  [MAX_THREADS];
   bit          sh_used  [MAX_THREADS];
   int          sh_head, sh_len, sh_idle, sh_window;
   logic [7:0]  sh_idle_id;

   sched_result_t pending_results[$];
   dir_row_t      dir_table[$];
   int            errors = 0;
   int            cycles = 0;
   int            idle_pct = 0;

   priority_ready_list_scheduler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_priority_req(req_priority_req),
      .req_target_tid(req_target_tid), .req_state_flags(req_state_flags),
      .req_sleep_ms(req_sleep_ms),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_running_tid(rsp_running_tid), .rsp_new_tid(rsp_new_tid),
      .rsp_load_valid(rsp_load_valid), .rsp_load_percent(rsp_load_percent),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_idle_thread_id(csr_idle_thread_id)
   );

   always #5 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("priority_ready_list_scheduler: mismatch");
         $finish;
      end
   end

   // move the head behind the first entry of higher priority, or to the tail if there is none
   function automatic void requeue_head();
      int h, rest, tmp, k;
      if (sh_len < 2) return;
      h = sh_head;
      rest = sh_len - 1;
      sh_head = sh_link[h];
      tmp = sh_head;
      k = 0;
      while (k + 1 < rest && sh_prio[tmp] <= sh_prio[h]) begin
         tmp = sh_link[tmp];
         k++;
      end
      sh_link[h] = (k + 1 < rest) ? sh_link[tmp] : 0;
      sh_link[tmp] = h;
   endfunction

   function automatic logic [7:0] head_tid();
      return sh_len ? sh_tid[sh_head] : 8'd0;
   endfunction

   function automatic sched_result_t run_tick();
      sched_result_t r;
      int budget, s, i;
      bit found;
      r = '0;
      budget = sh_len;
      found = 0;
      while (budget > 0 && sh_len > 0) begin
         budget--;
         requeue_head();
         s = sh_head;
         if (sh_flags[s] & FLAG_TERM) begin
            // terminated thread at the head is dropped
            sh_used[s] = 0;
            sh_len--;
            sh_head = sh_len ? sh_link[s] : 0;
            continue;
         end
         if (!(sh_flags[s] & FLAG_SLEEP)) begin
            found = 1;
            break;
         end
      end
      s = sh_head;
      for (i = 0; i < sh_len; i++) begin
         if (sh_count[s] > 0) begin
            sh_count[s]--;
            if (sh_count[s] == 0) sh_flags[s] &= ~FLAG_SLEEP;
         end
         s = sh_link[s];
      end
      if (!found || sh_tid[sh_head] == sh_idle_id) sh_idle++;
      sh_window++;
      if (sh_window >= TICKS_PER_SECOND) begin
         r.load_valid = 1'b1;
         r.load_percent = 7'(100 - sh_idle * 100 / sh_window);
         sh_idle = 0;
         sh_window = 0;
      end
      r.status = found ? ST_OK : ST_NONE_RUNNABLE;
      r.running_tid = found ? sh_tid[sh_head] : 8'd0;
      return r;
   endfunction

   function automatic sched_result_t predict_result(logic [1:0] op, logic [1:0] prio,
                                                    logic [7:0] target, logic [1:0] flags,
                                                    logic [15:0] ms);
      sched_result_t r;
      int id, s, i, slot, tail;
      bit have, hit;
      r = '0;
      case (op)
         OP_INSERT: begin
            id = 1;
            s = sh_head;
            for (i = 0; i < sh_len; i++) begin
               if (sh_tid[s] >= id) id = sh_tid[s] + 1;
               s = sh_link[s];
            end
            have = 0;
            slot = 0;
            for (i = 0; i < MAX_THREADS; i++)
               if (!have && !sh_used[i]) begin
                  slot = i;
                  have = 1;
               end
            if (sh_len >= MAX_THREADS || id > 255 || !have) begin
               r.status = ST_FULL;
            end else begin
               sh_tid[slot] = 8'(id);
               sh_prio[slot] = prio;
               sh_flags[slot] = '0;
               sh_count[slot] = '0;
               sh_link[slot] = 0;
               sh_used[slot] = 1;
               if (sh_len == 0) begin
                  sh_head = slot;
               end else begin
                  tail = sh_head;
                  for (i = 1; i < sh_len; i++) tail = sh_link[tail];
                  sh_link[tail] = slot;
               end
               sh_len++;
               r.new_tid = 8'(id);
            end
            r.running_tid = head_tid();
         end
         OP_TICK: r = run_tick();
         OP_SLEEP: begin
            if (sh_len > 0) begin
               sh_flags[sh_head] |= FLAG_SLEEP;
               sh_count[sh_head] = ms / MS_PER_TICK;
            end
            r = run_tick();
         end
         default: begin
            hit = 0;
            s = sh_head;
            for (i = 0; i < sh_len && !hit; i++) begin
               if (sh_tid[s] == target) begin
                  sh_flags[s] |= flags;
                  hit = 1;
               end
               s = sh_link[s];
            end
            r.status = hit ? ST_OK : ST_NOT_FOUND;
            r.running_tid = head_tid();
         end
      endcase
      return r;
   endfunction

   // random id of a thread in the list, or any id when the list is empty
   function automatic logic [7:0] pick_live_tid();
      int s, n;
      if (sh_len == 0) return 8'($urandom);
      n = $urandom_range(sh_len - 1);
      s = sh_head;
      repeat (n) s = sh_link[s];
      return sh_tid[s];
   endfunction

   function automatic logic [7:0] max_live_tid();
      int s, i;
      logic [7:0] m;
      m = '0;
      s = sh_head;
      for (i = 0; i < sh_len; i++) begin
         if (sh_tid[s] > m) m = sh_tid[s];
         s = sh_link[s];
      end
      return m;
   endfunction

   // result checker: every strobe is compared with the oldest expectation
   always @(posedge clock) begin
      sched_result_t e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: status %0d running %0d", $time,
                     rsp_status, rsp_running_tid);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t status: expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_running_tid !== e.running_tid) begin
               $display("%0t running_tid: expected %0d actual %0d", $time,
                        e.running_tid, rsp_running_tid);
               errors++;
            end
            if (rsp_new_tid !== e.new_tid) begin
               $display("%0t new_tid: expected %0d actual %0d", $time, e.new_tid, rsp_new_tid);
               errors++;
            end
            if (rsp_load_valid !== e.load_valid) begin
               $display("%0t load_valid: expected %0d actual %0d", $time,
                        e.load_valid, rsp_load_valid);
               errors++;
            end
            if (rsp_load_percent !== e.load_percent) begin
               $display("%0t load_percent: expected %0d actual %0d", $time,
                        e.load_percent, rsp_load_percent);
               errors++;
            end
         end
      end
   end

   // called at a falling edge; leaves start high when the next transaction follows at once
   task automatic send_item(logic [1:0] op, logic [1:0] prio, logic [7:0] target,
                            logic [1:0] flags, logic [15:0] ms,
                            bit known = 0, sched_result_t typed = '0);
      sched_result_t r;
      start <= 1'b1;
      req_opcode <= op;
      req_priority_req <= prio;
      req_target_tid <= target;
      req_state_flags <= flags;
      req_sleep_ms <= ms;
      do @(posedge clock); while (busy);
      r = predict_result(op, prio, target, flags, ms);
      pending_results.push_back(known ? typed : r);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic hold_off();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // register write, only with nothing in flight
   task automatic write_idle_id(logic [7:0] value);
      hold_off();
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_idle_thread_id <= value;
      do @(posedge clock); while (!csr_ready);
      sh_idle_id = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int r;
      logic [1:0] fl;
      logic [15:0] ms;
      r = $urandom_range(99);
      if (sh_len < 4 || r < 20) begin
         send_item(OP_INSERT, 2'($urandom), 8'($urandom), 2'($urandom), 16'($urandom));
      end else if (r < 55) begin
         send_item(OP_TICK, 2'($urandom), 8'($urandom), 2'($urandom), 16'($urandom));
      end else if (r < 70) begin
         // mostly short sleeps so threads wake within the run
         ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
         send_item(OP_SLEEP, 2'($urandom), 8'($urandom), 2'($urandom), ms);
      end else begin
         fl = ($urandom_range(2) == 0) ? FLAG_TERM : 2'($urandom);
         send_item(OP_SETF, 2'($urandom),
                   ($urandom_range(9) < 8) ? pick_live_tid() : 8'($urandom),
                   fl, 16'($urandom));
      end
   endtask

   initial begin
      sched_result_t typed;
      dir_row_t row;
      int i, p;
      logic [7:0] idle_ids [4];
      int pcts [4];

      foreach (sh_used[k]) sh_used[k] = 0;
      sh_head = 0; sh_len = 0; sh_idle = 0; sh_window = 0; sh_idle_id = 8'd1;

      // empty list first, then fill the table and overflow it
      dir_table.push_back('{OP_TICK, 2'd0, 8'd0, 2'd0, 16'd0, 1, ST_NONE_RUNNABLE, 8'd0, 8'd0});
      dir_table.push_back('{OP_SLEEP, 2'd3, 8'd255, 2'd3, 16'hFFFF, 1, ST_NONE_RUNNABLE,
                            8'd0, 8'd0});
      dir_table.push_back('{OP_SETF, 2'd0, 8'd255, 2'd3, 16'd0, 1, ST_NOT_FOUND, 8'd0, 8'd0});
      dir_table.push_back('{OP_INSERT, 2'd0, 8'd0, 2'd0, 16'd0, 1, ST_OK, 8'd1, 8'd1});
      dir_table.push_back('{OP_INSERT, 2'd3, 8'd0, 2'd0, 16'd0, 1, ST_OK, 8'd1, 8'd2});
      for (i = 2; i < MAX_THREADS; i++)
         dir_table.push_back('{OP_INSERT, 2'(i), 8'd0, 2'd0, 16'd0, 0, 2'd0, 8'd0, 8'd0});
      dir_table.push_back('{OP_INSERT, 2'd1, 8'd0, 2'd0, 16'd0, 1, ST_FULL, 8'd1, 8'd0});
      dir_table.push_back('{OP_SETF, 2'd0, 8'd1, FLAG_TERM, 16'd0, 0, 2'd0, 8'd0, 8'd0});
      dir_table.push_back('{OP_TICK, 2'd0, 8'd0, 2'd0, 16'd0, 0, 2'd0, 8'd0, 8'd0});
      // sleep shorter than one tick: the thread never wakes
      dir_table.push_back('{OP_SLEEP, 2'd0, 8'd0, 2'd0, 16'd9, 0, 2'd0, 8'd0, 8'd0});
      dir_table.push_back('{OP_SETF, 2'd0, 8'd200, 2'd1, 16'd0, 0, 2'd0, 8'd0, 8'd0});
      dir_table.push_back('{OP_SETF, 2'd0, 8'd3, FLAG_SLEEP, 16'd0, 0, 2'd0, 8'd0, 8'd0});
      dir_table.push_back('{OP_TICK, 2'd0, 8'd0, 2'd0, 16'd0, 0, 2'd0, 8'd0, 8'd0});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_table[k]) begin
         row = dir_table[k];
         typed = '{row.status, row.running_tid, row.new_tid, 1'b0, 7'd0};
         send_item(row.opcode, row.prio, row.target, row.flags, row.ms, row.known, typed);
      end

      // random phases, each with its idle id and idling mix set anew
      idle_ids = '{8'd0, 8'd255, 8'd1, 8'd0};
      pcts = '{0, 72, 72, 15};
      for (p = 0; p < 4; p++) begin
         write_idle_id(p == 3 ? pick_live_tid() : idle_ids[p]);
         idle_pct = pcts[p];
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 1 && i == ITEMS_PER_PHASE / 2) hold_off();
            random_item();
         end
      end

      // walk the id range up to its top: keep the newest thread, retire the rest
      idle_pct = 0;
      while (max_live_tid() < 8'd255) begin
         if (sh_len >= MAX_THREADS - 1 || (sh_len > 2 && $urandom_range(1) == 0))
            send_item(OP_SETF, 2'd0, sh_tid[sh_head] == max_live_tid() ?
                      sh_tid[sh_link[sh_head]] : sh_tid[sh_head], FLAG_TERM, 16'd0);
         else
            send_item(OP_INSERT, 2'($urandom), 8'd0, 2'd0, 16'd0);
         send_item(OP_TICK, 2'd0, 8'd0, 2'd0, 16'd0);
      end
      // no id left above the largest one in use
      send_item(OP_INSERT, 2'd2, 8'd0, 2'd0, 16'd0);

      // retire everything and restart ids from the bottom
      while (sh_len > 0) begin
         send_item(OP_SETF, 2'd0, pick_live_tid(), FLAG_TERM, 16'd0);
         send_item(OP_TICK, 2'd0, 8'd0, 2'd0, 16'd0);
      end
      send_item(OP_INSERT, 2'd0, 8'd0, 2'd0, 16'd0);

      hold_off();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("priority_ready_list_scheduler: match");
      end else begin
         $display("priority_ready_list_scheduler: mismatch");
      end
      $finish;
   end

endmodule

/* priority_ready_list_scheduler.f */
sv/prls_pkg.sv
sv/prls_ram.sv
sv/priority_ready_list_scheduler.sv
dv/priority_ready_list_scheduler_tb.sv
